// ----- rtl/tbrm_pkg.sv -----
// ----------------------------------------------------------------------------
// tbrm_pkg: shared types and constants of the title bar run merger
// Control register reset values and indexes, command and status structs.
// ----------------------------------------------------------------------------
package tbrm_pkg;

   localparam int DEF_MAX_BARS = 32;
   localparam int DEF_MAX_DIM  = 4096;
   localparam int CW           = 13;   // coordinate width

   localparam logic [1:0] CSR_MIN_RUN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_WHITE_LEVEL    = 2'd1;
   localparam logic [1:0] CSR_MIN_BAR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_MAX_BAR_HEIGHT = 2'd3;

   localparam logic [12:0] RST_MIN_RUN_WIDTH  = 13'd300;
   localparam logic [7:0]  RST_WHITE_LEVEL    = 8'd235;
   localparam logic [12:0] RST_MIN_BAR_HEIGHT = 13'd12;
   localparam logic [12:0] RST_MAX_BAR_HEIGHT = 13'd55;

   // controller -> datapath
   typedef struct packed {
      logic pixel_step;   // apply accepted pixel
      logic scan_start;   // reset table index
      logic scan_next;    // advance table index
      logic do_merge;     // write merged bar at index
      logic do_append;    // write new bar at end
      logic do_drop;      // mark overflow
      logic emit_load;    // load output register from current entry
      logic frame_clear;  // clear table and counters
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic run_closed;   // a qualifying run ended on the last pixel
      logic frame_end;    // last pixel closed the frame
      logic scan_done;    // index reached bars_in_use
      logic hit;          // current entry matches the run
      logic full;         // table is full
      logic pass;         // current entry passes the report limits
      logic more_pass;    // some later entry also passes
   } sts_type;

endpackage

// ----- rtl/title_bar_run_merger.sv -----
// ----------------------------------------------------------------------------
// title_bar_run_merger: near-white horizontal run finder and bar merger
// ----------------------------------------------------------------------------
// Pixels enter on req_* in raster order, with row_end and frame_end marks.
// Each pixel passes through a check state; a pixel that closes a qualifying
// run then walks the table one entry per cycle until an entry matches or the
// end is reached. req_ready is low meanwhile. On the frame's last pixel the
// table is walked again, entry by entry, and every bar within the limits is
// sent on rsp_*; last_bar marks the final one. Each result waits in the
// output register until rsp_ready; a stalled receiver holds the walk. After
// the walk the table is cleared. Configuration is written on csr_* (index
// 0..3) while idle; this binds the user, the block does not enforce it.
// Reset clears counters, table fill and overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module title_bar_run_merger
   import tbrm_pkg::*;
#(
   parameter int MAX_BARS = DEF_MAX_BARS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_row_end,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_bar_left,
   output logic [11:0] rsp_bar_top,
   output logic [12:0] rsp_bar_right,
   output logic [12:0] rsp_bar_bottom,
   output logic        rsp_last_bar,
   output logic        rsp_table_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   logic [12:0] min_w_ff, min_h_ff, max_h_ff;
   logic [7:0]  white_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_w_ff <= RST_MIN_RUN_WIDTH; white_ff <= RST_WHITE_LEVEL;
         min_h_ff <= RST_MIN_BAR_HEIGHT; max_h_ff <= RST_MAX_BAR_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_RUN_WIDTH:  min_w_ff <= csr_data;
            CSR_WHITE_LEVEL:    white_ff <= csr_data[7:0];
            CSR_MIN_BAR_HEIGHT: min_h_ff <= csr_data;
            CSR_MAX_BAR_HEIGHT: max_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tbrm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_last(rsp_last_bar),
      .cmd(cmd), .sts(sts)
   );

   tbrm_datapath #(.MAX_BARS(MAX_BARS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .red(req_red), .green(req_green), .blue(req_blue),
      .row_end(req_row_end), .frame_end(req_frame_end),
      .min_run_width(min_w_ff), .white_level(white_ff),
      .min_bar_height(min_h_ff), .max_bar_height(max_h_ff),
      .bar_left(rsp_bar_left), .bar_top(rsp_bar_top),
      .bar_right(rsp_bar_right), .bar_bottom(rsp_bar_bottom),
      .table_overflow(rsp_table_overflow)
   );
endmodule

// ----- rtl/tbrm_datapath.sv -----
// ----------------------------------------------------------------------------
// tbrm_datapath: pixel counters, run tracking and bar table
// Table held in flip-flop lanes; one entry per cycle while the index advances.
// ----------------------------------------------------------------------------
module tbrm_datapath
   import tbrm_pkg::*;
#(
   parameter int MAX_BARS = DEF_MAX_BARS
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   input  logic        row_end,
   input  logic        frame_end,
   input  logic [12:0] min_run_width,
   input  logic [7:0]  white_level,
   input  logic [12:0] min_bar_height,
   input  logic [12:0] max_bar_height,
   output logic [11:0] bar_left,
   output logic [11:0] bar_top,
   output logic [12:0] bar_right,
   output logic [12:0] bar_bottom,
   output logic        table_overflow
);
   localparam int IW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int NW = $clog2(MAX_BARS + 1);
   localparam logic [CW-1:0] DIM = CW'(DEF_MAX_DIM);

   logic [CW-1:0] col_ff, row_ff, start_ff;
   logic          active_ff, ovf_ff;
   logic [NW-1:0] used_ff;
   logic [NW-1:0] idx_ff;
   logic [CW-1:0] rs_ff, re_ff, rrow_ff;   // pending run
   logic          closed_ff, fend_ff;
   logic [CW-1:0] lt_ff [MAX_BARS];
   logic [CW-1:0] rt_ff [MAX_BARS];
   logic [CW-1:0] tp_ff [MAX_BARS];
   logic [CW-1:0] bt_ff [MAX_BARS];
   logic [MAX_BARS-1:0] pass_vec;

   // pixel stage
   logic          white, close_a, close_b, go_start;
   logic [CW-1:0] end_a, end_b, cend, cstart;
   logic          qual;
   always_comb begin
      white = red >= white_level && green >= white_level && blue >= white_level
              && col_ff < DIM && row_ff < DIM;
      close_a = !white && active_ff;
      go_start = white && !active_ff;
      end_a = col_ff;
      close_b = (row_end || frame_end) && (active_ff || go_start);
      end_b = col_ff + 1'b1;
      cstart = go_start ? col_ff : start_ff;
      cend = close_a ? end_a : end_b;
      qual = (close_a || close_b) && cend > cstart
             && (cend - cstart) >= min_run_width;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.frame_clear) begin
         col_ff <= '0; row_ff <= '0; start_ff <= '0; active_ff <= 1'b0;
         closed_ff <= 1'b0; fend_ff <= 1'b0;
      end else if (cmd.pixel_step) begin
         closed_ff <= qual;
         fend_ff   <= frame_end;
         rs_ff <= cstart; re_ff <= cend; rrow_ff <= row_ff;
         if (go_start) start_ff <= col_ff;
         active_ff <= (go_start || active_ff) && !close_a && !row_end && !frame_end;
         if (row_end || frame_end) begin
            col_ff <= '0;
            if (row_ff < DIM) row_ff <= row_ff + 1'b1;
         end else if (col_ff < DIM) col_ff <= col_ff + 1'b1;
      end else if (cmd.scan_start) begin
         closed_ff <= 1'b0;
      end
   end

   // current entry
   logic [IW-1:0] ix;
   logic [CW-1:0] el, er, et, eb, lo, hi, mn;
   logic [CW-1:0] w1, w2;
   logic          hit;
   assign ix = idx_ff[IW-1:0];
   always_comb begin
      el = lt_ff[ix]; er = rt_ff[ix]; et = tp_ff[ix]; eb = bt_ff[ix];
      lo = (el > rs_ff) ? el : rs_ff;
      hi = (er < re_ff) ? er : re_ff;
      w1 = (er > el) ? er - el : '0;
      w2 = re_ff - rs_ff;
      mn = (w1 < w2) ? w1 : w2;
      hit = ({1'b0, rrow_ff} <= {1'b0, eb} + 14'd2) && hi > lo &&
            ({2'b0, hi - lo} * 15'd3) >= ({1'b0, mn, 1'b0});
   end

   always_comb begin
      for (int i = 0; i < MAX_BARS; i++) begin
         pass_vec[i] = (NW'(i) < used_ff) &&
            ((bt_ff[i] > tp_ff[i] ? bt_ff[i] - tp_ff[i] : CW'(0)) >= min_bar_height) &&
            ((bt_ff[i] > tp_ff[i] ? bt_ff[i] - tp_ff[i] : CW'(0)) <= max_bar_height) &&
            ((rt_ff[i] > lt_ff[i] ? rt_ff[i] - lt_ff[i] : CW'(0)) >= min_run_width);
      end
   end

   logic more;
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < MAX_BARS; i++)
         if (NW'(i) > idx_ff && pass_vec[i]) more = 1'b1;
   end

   assign sts.run_closed = closed_ff;
   assign sts.frame_end  = fend_ff;
   assign sts.scan_done  = idx_ff >= used_ff;
   assign sts.hit        = hit;
   assign sts.full       = used_ff >= NW'(MAX_BARS);
   assign sts.pass       = pass_vec[ix];
   assign sts.more_pass  = more;

   always_ff @(posedge clock) begin
      if (reset || cmd.frame_clear) begin
         used_ff <= '0; ovf_ff <= 1'b0; idx_ff <= '0;
      end else begin
         if (cmd.scan_start) idx_ff <= '0;
         else if (cmd.scan_next) idx_ff <= idx_ff + 1'b1;
         if (cmd.do_append) used_ff <= used_ff + 1'b1;
         if (cmd.do_drop) ovf_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_merge) begin
         lt_ff[ix] <= (el < rs_ff) ? el : rs_ff;
         rt_ff[ix] <= (er > re_ff) ? er : re_ff;
         bt_ff[ix] <= rrow_ff + 1'b1;
      end else if (cmd.do_append) begin
         lt_ff[used_ff[IW-1:0]] <= rs_ff;
         rt_ff[used_ff[IW-1:0]] <= re_ff;
         tp_ff[used_ff[IW-1:0]] <= rrow_ff;
         bt_ff[used_ff[IW-1:0]] <= rrow_ff + 1'b1;
      end
      if (cmd.emit_load) begin
         bar_left <= el[11:0]; bar_top <= et[11:0];
         bar_right <= er; bar_bottom <= eb;
         table_overflow <= ovf_ff;
      end
   end
endmodule

// ----- rtl/tbrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbrm_ctrl: sequencer of pixel intake, table search and frame report
// Walks the table one entry a cycle to merge; reporting waits at each emitted bar.
// ----------------------------------------------------------------------------
module tbrm_ctrl
   import tbrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output logic    rsp_last,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_SEARCH = 3'd2,
                          S_REPORT = 3'd3, S_EMIT = 3'd4;
   logic [2:0] state_ff, state_in;
   logic       rv_ff, rv_in, last_ff, last_in;

   always_comb begin
      state_in = state_ff; rv_in = rv_ff; last_in = last_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.pixel_step = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.scan_start = 1'b1;
            if (sts.run_closed) state_in = S_SEARCH;
            else if (sts.frame_end) state_in = S_REPORT;
            else state_in = S_IDLE;
         end
         S_SEARCH: begin
            if (sts.scan_done) begin
               if (sts.full) cmd.do_drop = 1'b1;
               else cmd.do_append = 1'b1;
               state_in = sts.frame_end ? S_REPORT : S_IDLE;
               cmd.scan_start = 1'b1;
            end else if (sts.hit) begin
               cmd.do_merge = 1'b1;
               cmd.scan_start = 1'b1;
               state_in = sts.frame_end ? S_REPORT : S_IDLE;
            end else cmd.scan_next = 1'b1;
         end
         S_REPORT: begin
            if (sts.scan_done) begin
               cmd.frame_clear = 1'b1;
               state_in = S_IDLE;
            end else if (sts.pass) begin
               cmd.emit_load = 1'b1;
               rv_in = 1'b1;
               last_in = !sts.more_pass;
               state_in = S_EMIT;
            end else cmd.scan_next = 1'b1;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               rv_in = 1'b0;
               cmd.scan_next = 1'b1;
               state_in = S_REPORT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; last_ff <= last_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("input taken during report");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.do_merge, cmd.do_append, cmd.do_drop}) <= 1)
      else $error("two table writes");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule
